// ----- rtl/core/prime_table_trial_factorizer_macros.svh -----
// Assertion macros used by the port checker file.
`ifndef PRIME_TABLE_TRIAL_FACTORIZER_MACROS_SVH
`define PRIME_TABLE_TRIAL_FACTORIZER_MACROS_SVH

// Same-cycle implication under reset.
`define PTTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pttf assertion failed");

// Next-cycle implication under reset.
`define PTTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pttf assertion failed");

`endif

// ----- rtl/core/pttf_pkg.sv -----
// Types and constants of the prime table trial factorizer.
package pttf_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int KW          = $clog2(MAX_RESULTS + 1);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FACTOR = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [9:0]  entry_index;
        logic [31:0] entry_prime;
        logic [31:0] number;
        logic [10:0] table_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0] prime_factor;
        logic        empty_res;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_FETCH,
        ST_TEST,
        ST_DIV,
        ST_EVAL,
        ST_PUSH,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic start;
        logic load;
        logic rd;
        logic latch_div;
        logic adv;
        logic div_start;
        logic div_step;
        logic capture;
        logic emit;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic skip;
        logic div_done;
        logic rem_zero;
        logic has_pend;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/pttf_ctrl.sv -----
// Controller state machine of the trial factorizer.
module pttf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_op,
    input  pttf_pkg::t_stat i_stat,
    output pttf_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import pttf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_FACTOR) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_NEXT;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_NEXT: begin
                if (i_stat.walk_done) begin
                    n_state = ST_FINAL;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.latch_div = 1'b1;
                n_state         = ST_TEST;
            end
            ST_TEST: begin
                if (i_stat.skip) begin
                    o_cmd.adv = 1'b1;
                    n_state   = ST_NEXT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_stat.rem_zero) begin
                    o_cmd.adv = 1'b1;
                    n_state   = ST_NEXT;
                end else if (i_stat.has_pend) begin
                    n_state = ST_PUSH;
                end else begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_TEST;
                end
            end
            ST_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.capture = 1'b1;
                    n_state       = ST_TEST;
                end
            end
            ST_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/pttf_dp.sv -----
// Datapath of the trial factorizer: prime table, walk counters, serial divider, result register.
module pttf_dp #(
    parameter int TABLE_DEPTH = 1024,
    parameter int NUM_WIDTH   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pttf_pkg::t_in_item i_in_data,
    input  pttf_pkg::t_cmd     i_cmd,
    input  logic               i_out_stall,
    output pttf_pkg::t_stat    o_stat,
    output logic               o_out_valid,
    output pttf_pkg::t_out_item o_out_data
);
    import pttf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] r_table [TABLE_DEPTH];
    logic [NUM_WIDTH-1:0] r_rd;
    logic [NUM_WIDTH-1:0] r_residue;
    logic [NUM_WIDTH-1:0] r_div;
    logic [NUM_WIDTH-1:0] r_rem;
    logic [NUM_WIDTH-1:0] r_quo;
    logic [NUM_WIDTH-1:0] r_pend;
    logic [SW-1:0]        r_step;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_cnt;
    logic [KW-1:0]        r_k;
    logic                 r_has_pend;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [31:0]          cnt_ext;
    logic [31:0]          cnt_sat;
    logic                 wr_ok;
    logic [NUM_WIDTH:0]   shifted;
    logic [NUM_WIDTH:0]   div_ext;
    logic                 q_bit;
    logic                 k_full;

    assign cnt_ext = 32'(i_in_data.table_count);
    assign cnt_sat = (cnt_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_ext;
    assign wr_ok   = (32'(i_in_data.entry_index) < 32'(TABLE_DEPTH));
    assign shifted = {r_rem, r_quo[NUM_WIDTH-1]};
    assign div_ext = {1'b0, r_div};
    assign q_bit   = (shifted >= div_ext);
    assign k_full  = (r_k == KW'(MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_table[AW'(i_in_data.entry_index)] <= NUM_WIDTH'(i_in_data.entry_prime);
        end
        if (i_cmd.rd) begin
            r_rd <= r_table[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_residue <= NUM_WIDTH'(i_in_data.number);
            r_cnt     <= CW'(cnt_sat);
        end else if (i_cmd.capture) begin
            r_residue <= r_quo;
            r_pend    <= r_div;
        end
        if (i_cmd.latch_div) begin
            r_div <= r_rd;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quo  <= r_residue;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? NUM_WIDTH'(shifted - div_ext) : shifted[NUM_WIDTH-1:0];
            r_quo  <= {r_quo[NUM_WIDTH-2:0], q_bit};
            r_step <= r_step + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_k        <= '0;
            r_has_pend <= 1'b0;
        end else if (i_cmd.start) begin
            r_idx      <= '0;
            r_k        <= '0;
            r_has_pend <= 1'b0;
        end else begin
            if (i_cmd.adv) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.capture) begin
                r_k        <= r_k + KW'(1);
                r_has_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.prime_factor <= r_has_pend ? 32'(r_pend) : 32'd0;
            r_out.empty_res    <= !r_has_pend;
            r_out.last         <= i_cmd.emit_last;
        end
    end

    assign o_stat.walk_done = (r_idx >= r_cnt) || (r_residue < NUM_WIDTH'(2)) || k_full;
    assign o_stat.skip      = (r_div < NUM_WIDTH'(2)) || (r_div > r_residue) || k_full;
    assign o_stat.div_done  = (r_step == SW'(NUM_WIDTH - 1));
    assign o_stat.rem_zero  = (r_rem == '0);
    assign o_stat.has_pend  = r_has_pend;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/prime_table_trial_factorizer.sv -----
// Top level of the prime table trial factorizer.
// A load transaction writes one prime table entry and returns nothing; a load at
// an index at or above TABLE_DEPTH is dropped. A factor transaction walks the first
// table_count entries (saturated to TABLE_DEPTH) and returns each dividing prime once per
// multiplicity, the final one marked last, or one empty result when nothing divides. One
// transaction is worked at a time. A tried entry below two or above the residue is skipped
// without a division; every other entry, and each found factor, takes a pass through the one
// bit-serial restoring divider, and an output stall can hold the walk; at most 32 factors
// are returned, and the walk ends early once the residue reaches one.
module prime_table_trial_factorizer #(
    parameter int TABLE_DEPTH = 1024,
    parameter int NUM_WIDTH   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pttf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pttf_pkg::t_out_item o_out_data
);
    import pttf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pttf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.opcode),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pttf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_WIDTH   (NUM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/pttf_chk.sv -----
// Port checker of the trial factorizer and its bind.
`include "prime_table_trial_factorizer_macros.svh"

module pttf_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input pttf_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pttf_pkg::t_out_item o_out_data
);
    import pttf_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    `PTTF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `PTTF_ASSERT_NOW(a_empty_form, i_clk, i_rst_n, o_out_valid && o_out_data.empty_res, o_out_data.prime_factor == 32'd0 && o_out_data.last)
    `PTTF_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, in_acc && i_in_data.opcode == OP_LOAD && !o_out_valid, !o_out_valid)
    `PTTF_ASSERT_NEXT(a_factor_busy, i_clk, i_rst_n, in_acc && i_in_data.opcode == OP_FACTOR, o_in_stall)

endmodule

bind prime_table_trial_factorizer pttf_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- verif/pttf_checker.sv -----
// Scoreboard that mirrors the prime table and checks every factor result of the factorizer.
`timescale 1ns / 1ps
module pttf_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  pttf_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pttf_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending_count
);
    import pttf_pkg::*;

    logic [31:0] prime_store [TABLE_DEPTH];
    t_out_item   awaited_factors [$];

    function automatic void predict_factors(input t_in_item item);
        logic [31:0] residue;
        logic [31:0] divisor;
        int          span;
        int          emitted;
        t_out_item   held;
        residue = item.number;
        span    = (item.table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(item.table_count);
        emitted = 0;
        held    = '0;
        for (int i = 0; i < span && residue > 1 && emitted < MAX_RESULTS; i++) begin
            divisor = prime_store[i];
            if (divisor >= 2) begin
                while (residue != 1 && residue % divisor == 0 && emitted < MAX_RESULTS) begin
                    residue = residue / divisor;
                    if (emitted > 0) begin
                        awaited_factors.push_back(held);
                    end
                    held.prime_factor = divisor;
                    held.empty_res    = 1'b0;
                    held.last         = 1'b0;
                    emitted++;
                end
            end
        end
        if (emitted == 0) begin
            held.prime_factor = '0;
            held.empty_res    = 1'b1;
        end
        held.last = 1'b1;
        awaited_factors.push_back(held);
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            awaited_factors.delete();
            o_fail_count    = 0;
            o_pending_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.opcode == OP_LOAD) begin
                    if (int'(i_in_data.entry_index) < TABLE_DEPTH) begin
                        prime_store[i_in_data.entry_index] = i_in_data.entry_prime;
                    end
                end else begin
                    predict_factors(i_in_data);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (awaited_factors.size() == 0) begin
                    $error("unexpected result: prime_factor %0d empty_res %0b last %0b",
                           got.prime_factor, got.empty_res, got.last);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = awaited_factors.pop_front();
                    if (got.prime_factor !== want.prime_factor) begin
                        $error("prime_factor expected %0d actual %0d",
                               want.prime_factor, got.prime_factor);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.empty_res !== want.empty_res) begin
                        $error("empty_res expected %0b actual %0b", want.empty_res, got.empty_res);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.last !== want.last) begin
                        $error("last expected %0b actual %0b", want.last, got.last);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending_count = awaited_factors.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Stimulus and verdict for the prime table trial factorizer: table loads, factor requests, stalls.
`timescale 1ns / 1ps
module tb_top;
    import pttf_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int FILL_ENTRIES = 64;
    localparam int RANDOM_ITEMS = 205;
    localparam int QUIET_ITEMS  = 30;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    logic      idle_off;
    int        fail_count;
    int        pending_count;

    logic [31:0] small_primes [TABLE_DEPTH];

    prime_table_trial_factorizer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    pttf_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) scoreboard (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input t_in_item item);
        int gap;
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_entry(input logic [9:0] index, input logic [31:0] value);
        t_in_item item;
        item.opcode      = OP_LOAD;
        item.entry_index = index;
        item.entry_prime = value;
        item.number      = $urandom;
        item.table_count = 11'($urandom_range(0, 2047));
        send_item(item);
    endtask

    task automatic factor_number(input logic [31:0] value, input logic [10:0] count);
        t_in_item item;
        item.opcode      = OP_FACTOR;
        item.entry_index = 10'($urandom_range(0, TABLE_DEPTH - 1));
        item.entry_prime = $urandom;
        item.number      = value;
        item.table_count = count;
        send_item(item);
    endtask

    function automatic logic [31:0] compose_number(input int pool);
        logic [63:0] value;
        logic [63:0] pick;
        int          parts;
        value = 64'd1;
        parts = $urandom_range(1, 31);
        for (int j = 0; j < parts; j++) begin
            pick = 64'(small_primes[$urandom_range(0, pool - 1)]);
            if (value * pick <= 64'hFFFF_FFFF) begin
                value = value * pick;
            end
        end
        return value[31:0];
    endfunction

    initial begin
        int          stall_left;
        logic        stall_on;
        out_stall  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (idle_off) begin
                out_stall <= 1'b0;
            end else if (stall_left == 0) begin
                stall_on   = ($urandom_range(0, 2) == 0);
                stall_left = $urandom_range(1, 15);
                out_stall <= stall_on;
            end else begin
                stall_left = stall_left - 1;
            end
        end
    end

    initial begin
        int          found;
        int unsigned cand;
        bit          is_prime;
        int          pool;
        int          pick;
        logic [10:0] count;
        logic [9:0]  index;
        logic [31:0] value;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        idle_off = 1'b0;

        found = 0;
        cand  = 2;
        while (found < TABLE_DEPTH) begin
            is_prime = 1'b1;
            for (int d = 0; d < found && small_primes[d] * small_primes[d] <= cand; d++) begin
                if (cand % small_primes[d] == 0) is_prime = 1'b0;
            end
            if (is_prime) begin
                small_primes[found] = cand;
                found++;
            end
            cand++;
        end

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill the leading entries that every walk stays within
        for (int i = 0; i < FILL_ENTRIES; i++) begin
            load_entry(i[9:0], small_primes[i]);
        end

        factor_number(32'd0, 11'd2047);
        factor_number(32'd1, 11'd1024);
        factor_number(32'd12, 11'd0);
        factor_number(32'h8000_0000, 11'd1);
        factor_number(32'hFFFF_FFFF, 11'd10);
        factor_number(32'd223092870, 11'd1100);
        factor_number(32'd4294967291, 11'd3);
        factor_number(32'd223092870, 11'd9);
        load_entry(10'd0, 32'd0);
        load_entry(10'd1, 32'd1);
        factor_number(32'd35, 11'd4);
        load_entry(10'd0, 32'd4);
        factor_number(32'd48, 11'd2);
        load_entry(10'd0, 32'hFFFF_FFFF);
        factor_number(32'hFFFF_FFFF, 11'd1);
        load_entry(10'd1, 32'd4294967291);
        factor_number(32'd4294967291, 11'd2);
        load_entry(10'd0, 32'd2);
        load_entry(10'd1, 32'd3);
        factor_number(32'd6, 11'd2);
        factor_number(32'd2, 11'd1);

        for (int j = 0; j < RANDOM_ITEMS; j++) begin
            idle_off = (RANDOM_ITEMS - j) <= QUIET_ITEMS;
            if ($urandom_range(0, 4) == 0) begin
                index = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 63))
                                                    : 10'($urandom_range(0, TABLE_DEPTH - 1));
                case ($urandom_range(0, 7))
                    0:       value = 32'd0;
                    1:       value = 32'd1;
                    2:       value = $urandom;
                    3:       value = small_primes[$urandom_range(0, TABLE_DEPTH - 1)];
                    default: value = small_primes[index];
                endcase
                load_entry(index, value);
            end else begin
                count = ($urandom_range(0, 47) == 0) ? 11'($urandom_range(49, FILL_ENTRIES))
                                                     : 11'($urandom_range(0, 48));
                pool  = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
                if (pool == 0) pool = 1;
                pick = $urandom_range(0, 9);
                if (pick <= 5) begin
                    value = compose_number(pool);
                end else if (pick <= 7) begin
                    value = $urandom;
                end else if (pick == 8) begin
                    value = $urandom_range(0, 3);
                end else begin
                    value = compose_number((pool + 8 > TABLE_DEPTH) ? TABLE_DEPTH : pool + 8);
                end
                factor_number(value, count);
            end
        end

        idle_off = 1'b1;
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0) begin
            $display("prime_table_trial_factorizer: match");
        end else begin
            $display("prime_table_trial_factorizer: mismatch");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("prime_table_trial_factorizer: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pttf_pkg.sv
rtl/core/pttf_ctrl.sv
rtl/core/pttf_dp.sv
rtl/core/prime_table_trial_factorizer.sv
rtl/core/pttf_chk.sv
verif/pttf_checker.sv
verif/tb_top.sv
